### rtl/sorted_insertion_queue_macros.svh
// ---------------------------------------------------------------------------
// sorted insertion queue assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef SORTED_INSERTION_QUEUE_MACROS_SVH
`define SORTED_INSERTION_QUEUE_MACROS_SVH

// clocked property, off while in reset
`define SIQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked property that is also checked during reset
`define SIQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/siq_pkg.sv
// ---------------------------------------------------------------------------
// siq_pkg
// types and constants shared by the sorted insertion queue modules
// ---------------------------------------------------------------------------
package siq_pkg;

  // default number of cells
  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned FILL_W = 5;

  // most negative key, returned when no key leaves the queue
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

  // operation of an input word
  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } siq_mode_e;

  // result status
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } siq_status_e;

  // broadcast to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } siq_ctrl_t;

endpackage

### rtl/siq_cell.sv
// ---------------------------------------------------------------------------
// siq_cell
// one slot of the sorted row: compares against the broadcast key and either
// holds, takes the new key, takes its left neighbour or its right neighbour
// ---------------------------------------------------------------------------
module siq_cell (
  input  logic                                clk_i,
  input  siq_pkg::siq_ctrl_t                  ctrl_i,
  input  logic                                valid_i,
  input  logic                                prev_place_i,
  input  logic signed [siq_pkg::KEY_W-1:0]    prev_key_i,
  input  logic signed [siq_pkg::KEY_W-1:0]    next_key_i,
  output logic                                place_o,
  output logic signed [siq_pkg::KEY_W-1:0]    key_o
);

  logic signed [siq_pkg::KEY_W-1:0] key_q, key_d;

  // new key belongs here or further left: slot empty or holds a smaller key
  assign place_o = !valid_i || (key_q < ctrl_i.key);

  // next slot content
  always_comb begin
    key_d = key_q;
    if (ctrl_i.ins) begin
      if (prev_place_i) begin
        key_d = prev_key_i;
      end else if (place_o) begin
        key_d = ctrl_i.key;
      end
    end else if (ctrl_i.rem) begin
      key_d = next_key_i;
    end
  end

  // slot register
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

### rtl/sorted_insertion_queue.sv
// A result strobes on valid_o in the cycle after its word is accepted.
// Throughput: one word per cycle; all cells compare and shift in parallel,
// so busy stays low and the result register can be refilled every cycle.
// Reset: asynchronous, active low; clears the fill count and the strobe.
// Stored keys are not reset; slots at or beyond the fill count are unused.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
// sorted_insertion_queue
// bounded priority queue of signed keys held in descending order in a row
// of compare-and-shift cells
// ---------------------------------------------------------------------------
module sorted_insertion_queue #(
  parameter int unsigned DEPTH = siq_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode_i,
  input  logic signed [siq_pkg::KEY_W-1:0]    key_i,
  output logic                                valid_o,
  output logic [1:0]                          status_o,
  output logic signed [siq_pkg::KEY_W-1:0]    data_o,
  output logic [siq_pkg::FILL_W-1:0]          fill_count_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                     accept;
  logic                     full, empty;
  logic [CW-1:0]            count_q, count_d;
  siq_pkg::siq_ctrl_t       ctrl;
  logic [DEPTH-1:0]         valid;
  logic [DEPTH-1:0]         place;
  logic signed [siq_pkg::KEY_W-1:0] cell_key [DEPTH];

  logic                     strobe_q;
  logic [1:0]               status_q, status_d;
  logic signed [siq_pkg::KEY_W-1:0] data_q, data_d;
  logic [siq_pkg::FILL_W-1:0] fill_q;
  logic [CW+siq_pkg::FILL_W-1:0] fill_ext;

  // every cycle can take a word
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  // broadcast control
  always_comb begin
    ctrl.key = key_i;
    ctrl.ins = accept && (mode_i == siq_pkg::MODE_INSERT) && !full;
    ctrl.rem = accept && (mode_i == siq_pkg::MODE_REMOVE) && !empty;
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             prev_place;
    logic signed [siq_pkg::KEY_W-1:0] prev_key, next_key;

    assign valid[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_place = 1'b0;
      assign prev_key   = siq_pkg::KEY_MIN;
    end else begin : g_mid
      assign prev_place = place[i-1];
      assign prev_key   = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_key = siq_pkg::KEY_MIN;
    end else begin : g_inner
      assign next_key = cell_key[i+1];
    end

    siq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (valid[i]),
      .prev_place_i (prev_place),
      .prev_key_i   (prev_key),
      .next_key_i   (next_key),
      .place_o      (place[i]),
      .key_o        (cell_key[i])
    );
  end

  // fill count and result word
  always_comb begin
    count_d  = count_q;
    status_d = siq_pkg::ST_INSERTED;
    data_d   = siq_pkg::KEY_MIN;
    if (mode_i == siq_pkg::MODE_INSERT) begin
      if (full) begin
        status_d = siq_pkg::ST_DROPPED;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else begin
      if (empty) begin
        status_d = siq_pkg::ST_EMPTY;
      end else begin
        status_d = siq_pkg::ST_REMOVED;
        data_d   = cell_key[0];
        count_d  = count_q - CW'(1);
      end
    end
  end

  assign fill_ext = {{siq_pkg::FILL_W{1'b0}}, count_d};

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      data_q   <= data_d;
      fill_q   <= fill_ext[siq_pkg::FILL_W-1:0];
    end
  end

  assign valid_o      = strobe_q;
  assign status_o     = status_q;
  assign data_o       = data_q;
  assign fill_count_o = fill_q;

endmodule

### rtl/siq_checker.sv
// ---------------------------------------------------------------------------
// siq_checker
// port level checks of the sorted insertion queue, bound to the top level
// ---------------------------------------------------------------------------
`include "sorted_insertion_queue_macros.svh"

module siq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                mode_i,
  input logic                                valid_o,
  input logic [1:0]                          status_o,
  input logic signed [siq_pkg::KEY_W-1:0]    data_o,
  input logic [siq_pkg::FILL_W-1:0]          fill_count_o
);

  // one result for each accepted word, in the next cycle
  `SIQ_ASSERT(a_result_follows, (start && !busy) |=> valid_o, "accepted word gave no result")
  `SIQ_ASSERT(a_no_spurious, !(start && !busy) |=> !valid_o, "result without accepted word")
  // status matches the operation of the word
  `SIQ_ASSERT(a_status_mode, (start && !busy) |=> ((status_o == siq_pkg::ST_REMOVED || status_o == siq_pkg::ST_EMPTY) == $past(mode_i)), "status does not match mode")
  // only a real remove carries a key
  `SIQ_ASSERT(a_data_min, (valid_o && status_o != siq_pkg::ST_REMOVED) |-> (data_o == siq_pkg::KEY_MIN), "data not most negative")
  // an empty remove leaves nothing stored
  `SIQ_ASSERT_ALWAYS(a_empty_zero, (rst_ni && valid_o && status_o == siq_pkg::ST_EMPTY) |-> (fill_count_o == '0), "empty status with nonzero count")

endmodule

bind sorted_insertion_queue siq_checker u_siq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .mode_i       (mode_i),
  .valid_o      (valid_o),
  .status_o     (status_o),
  .data_o       (data_o),
  .fill_count_o (fill_count_o)
);

### dv/sorted_insertion_queue_tb.sv
// ---------------------------------------------------------------------------
// sorted_insertion_queue_tb
// checks the sorted insertion queue word by word against a queue-based
// predictor: directed corner words first, then bursts of random inserts and
// removes that fill, overflow and drain the queue under varying sender gaps
// ---------------------------------------------------------------------------
module sorted_insertion_queue_tb;
  import siq_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned HALF_PERIOD  = 2;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  // one input word and one result word
  typedef struct {
    siq_mode_e               mode;
    logic signed [KEY_W-1:0] key;
  } word_t;

  typedef struct {
    siq_status_e             status;
    logic signed [KEY_W-1:0] data;
    logic [FILL_W-1:0]       fill;
  } result_t;

  logic                    clk_i  = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start  = 1'b0;
  logic                    busy;
  logic                    mode_i = MODE_INSERT;
  logic signed [KEY_W-1:0] key_i  = '0;
  logic                    valid_o;
  logic [1:0]              status_o;
  logic signed [KEY_W-1:0] data_o;
  logic [FILL_W-1:0]       fill_count_o;

  word_t                   word_backlog[$];
  result_t                 due_results[$];
  logic signed [KEY_W-1:0] model_keys[$];
  logic                    took_word = 1'b0;
  int unsigned             idle_pct = 0;
  int unsigned             fail_count = 0;
  logic signed [KEY_W-1:0] last_key = '0;
  int unsigned             n_inserted = 0;
  int unsigned             n_dropped = 0;
  int unsigned             n_removed = 0;
  int unsigned             n_empty = 0;
  int unsigned             peak_fill = 0;

  sorted_insertion_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .key_i       (key_i),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .data_o      (data_o),
    .fill_count_o(fill_count_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // expected result of one word; updates the predicted key order
  function automatic result_t predict_queue_op(input word_t w);
    result_t r;
    int      pos;
    r.data = KEY_MIN;
    if (w.mode == MODE_INSERT) begin
      if (model_keys.size() >= DEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        pos = model_keys.size();
        for (int i = 0; i < model_keys.size(); i++) begin
          if (model_keys[i] < w.key) begin
            pos = i;
            break;
          end
        end
        model_keys.insert(pos, w.key);
        r.status = ST_INSERTED;
      end
    end else begin
      if (model_keys.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.data   = model_keys.pop_front();
        r.status = ST_REMOVED;
      end
    end
    r.fill = FILL_W'(model_keys.size());
    return r;
  endfunction

  // keys biased towards extremes and repeats so that equal keys meet
  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom;
      4, 5, 6:    k = $signed($urandom_range(0, 8)) - 4;
      7:          k = KEY_MIN;
      8:          k = KEY_MAX;
      default:    k = last_key;
    endcase
    last_key = k;
    return k;
  endfunction

  task automatic push_word(input siq_mode_e m, input logic signed [KEY_W-1:0] k);
    word_t w;
    w.mode = m;
    w.key  = k;
    word_backlog.push_back(w);
  endtask

  // bursts that lean towards filling or draining the queue
  task automatic push_random_words(input int n);
    int left;
    int run;
    int ins_pct;
    left = n;
    while (left > 0) begin
      run = $urandom_range(1, 40);
      case ($urandom_range(0, 4))
        0:       ins_pct = 100;
        1:       ins_pct = 75;
        2:       ins_pct = 50;
        3:       ins_pct = 25;
        default: ins_pct = 0;
      endcase
      for (int k = 0; k < run && left > 0; k++) begin
        if ($urandom_range(0, 99) < ins_pct) begin
          push_word(MODE_INSERT, pick_key());
        end else begin
          push_word(MODE_REMOVE, $urandom);
        end
        left--;
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (word_backlog.size() != 0 || start || due_results.size() != 0);
  endtask

  // driver: presents the next word at the falling edge, holds it until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || took_word) begin
      if (word_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start  <= 1'b1;
        mode_i <= word_backlog[0].mode;
        key_i  <= word_backlog[0].key;
        void'(word_backlog.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the strobed result, then predict the word taken now
  always @(posedge clk_i) begin
    result_t exp_r;
    word_t   w;
    took_word <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (valid_o) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: status %0d data %0d fill %0d",
                 status_o, data_o, fill_count_o);
          fail_count++;
        end else begin
          exp_r = due_results.pop_front();
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            fail_count++;
          end
          if (data_o !== exp_r.data) begin
            $error("data: expected %0d, got %0d", exp_r.data, data_o);
            fail_count++;
          end
          if (fill_count_o !== exp_r.fill) begin
            $error("fill_count: expected %0d, got %0d", exp_r.fill, fill_count_o);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        w.mode = siq_mode_e'(mode_i);
        w.key  = key_i;
        exp_r  = predict_queue_op(w);
        due_results.push_back(exp_r);
        case (exp_r.status)
          ST_INSERTED: n_inserted++;
          ST_DROPPED:  n_dropped++;
          ST_REMOVED:  n_removed++;
          default:     n_empty++;
        endcase
        if (exp_r.fill > peak_fill) peak_fill = exp_r.fill;
      end
    end
  end

  // stimulus and end of run
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners: empty remove, extremes, equal keys, overflow
    idle_pct = 20;
    push_word(MODE_REMOVE, KEY_MAX);
    push_word(MODE_INSERT, KEY_MAX);
    push_word(MODE_INSERT, KEY_MIN);
    push_word(MODE_INSERT, '0);
    push_word(MODE_INSERT, -1);
    push_word(MODE_INSERT, 5);
    push_word(MODE_INSERT, 5);
    push_word(MODE_INSERT, 5);
    push_word(MODE_REMOVE, '0);
    push_word(MODE_REMOVE, -1);
    push_word(MODE_REMOVE, KEY_MIN);
    for (int i = 0; i < 12; i++) push_word(MODE_INSERT, (i % 3 == 0) ? KEY_MIN : $urandom);
    push_word(MODE_INSERT, KEY_MAX);
    push_random_words(526);
    wait_drained();

    idle_pct = 78;
    push_random_words(550);
    wait_drained();

    idle_pct = 0;
    push_random_words(550);
    wait_drained();
    repeat (5) @(posedge clk_i);

    $display("covered %0d inserts, %0d dropped on full, %0d removes, %0d empty removes",
             n_inserted, n_dropped, n_removed, n_empty);
    $display("peak fill %0d of %0d", peak_fill, DEPTH);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("tb: failure");
    $finish;
  end

endmodule
